>>> rtl/endec_pkg.sv
// Shared types, constants and decode helpers for the escaped name decoder.
package endec_pkg;

    // Decode phase of the front end
    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX0  = 3'd2,
        PH_HEX1  = 3'd3,
        PH_UPPER = 3'd4
    } t_phase;

    // Decode modes
    localparam logic [1:0] MODE_DASH    = 2'd0;
    localparam logic [1:0] MODE_HEX     = 2'd1;
    localparam logic [1:0] MODE_LETTERS = 2'd2;
    localparam logic [1:0] MODE_ALT     = 2'd3;

    // Register map (byte addresses)
    localparam int          ADDR_W           = 3;
    localparam logic [ADDR_W-1:0] ADDR_ESCAPE_CHAR = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_DECODE_MODE = 3'd4;

    // Reset values of the registers
    localparam logic [7:0] RST_ESCAPE_CHAR = 8'd92;
    localparam logic [1:0] RST_DECODE_MODE = MODE_LETTERS;

    // Character codes
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_U_LO  = 8'h75;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One queue entry: the one or two bytes caused by one input transaction
    typedef struct packed {
        logic       two;     // second byte present
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       fin;     // input ended the string
    } t_entry;

    // Hex digit: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // ASCII upper case for a..z only
    function automatic logic [7:0] upper_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h61:8'h7A]}) begin
            r = b - 8'd32;
        end
        return r;
    endfunction

    // Letter code map: {hit, mapped byte}
    function automatic logic [8:0] letter_code(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h61:   r = {1'b1, CH_AT};
            8'h63:   r = {1'b1, CH_COLON};
            8'h64:   r = {1'b1, CH_DOT};
            8'h68:   r = {1'b1, CH_SEMI};
            8'h6D:   r = {1'b1, CH_DASH};
            8'h70:   r = {1'b1, CH_PLUS};
            8'h76:   r = {1'b1, CH_COMMA};
            default: r = {1'b0, b};
        endcase
        return r;
    endfunction

endpackage

>>> rtl/endec_front.sv
// Front end: accepts raw bytes, tracks the escape phase, builds queue entries.
module endec_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [7:0]           i_escape_char,
    input  logic [1:0]           i_decode_mode,
    input  logic                 i_q_full,
    output logic                 o_push,
    output endec_pkg::t_entry    o_entry
);

    endec_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_hex, n_hex;

    logic       accept;
    logic [1:0] mode;
    logic       dash_map;
    logic       is_esc;
    logic       is_x;
    logic       is_u_code;
    logic [4:0] hd;
    logic [7:0] acc;
    logic       plain_emit;
    logic       plain_to_esc;
    logic [7:0] plain_out;
    logic [8:0] lc;
    logic [1:0] cnt;
    logic [7:0] b0, b1;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Shared decode terms
    always_comb begin
        mode         = (i_decode_mode == endec_pkg::MODE_ALT) ? endec_pkg::MODE_HEX
                                                               : i_decode_mode;
        dash_map     = (mode == endec_pkg::MODE_DASH) && (i_byte == endec_pkg::CH_DASH);
        is_esc       = (i_byte == i_escape_char);
        is_x         = i_byte inside {endec_pkg::CH_X_LO, endec_pkg::CH_X_UP};
        is_u_code    = (mode == endec_pkg::MODE_LETTERS) && !is_esc
                       && (i_byte == endec_pkg::CH_U_LO);
        hd           = endec_pkg::hex_digit(i_byte);
        acc          = {r_hex[3:0], hd[3:0]};
        plain_emit   = dash_map || !is_esc || i_last;
        plain_to_esc = !plain_emit;
        plain_out    = dash_map ? endec_pkg::CH_SLASH : i_byte;
        lc           = endec_pkg::letter_code(i_byte);
    end

    // Next state
    always_comb begin
        n_phase = endec_pkg::PH_PLAIN;
        n_hex   = r_hex;
        case (r_phase)
            endec_pkg::PH_ESC: begin
                if (is_x) begin
                    n_hex = 8'd0;
                    if (!i_last) n_phase = endec_pkg::PH_HEX0;
                end else if (is_u_code && !i_last) begin
                    n_phase = endec_pkg::PH_UPPER;
                end
            end
            endec_pkg::PH_HEX0, endec_pkg::PH_HEX1: begin
                if (hd[4]) begin
                    if (r_phase == endec_pkg::PH_HEX1 || i_last) begin
                        n_hex = 8'd0;
                    end else begin
                        n_phase = endec_pkg::PH_HEX1;
                        n_hex   = acc;
                    end
                end else begin
                    n_hex = 8'd0;
                    if (plain_to_esc) n_phase = endec_pkg::PH_ESC;
                end
            end
            endec_pkg::PH_UPPER: begin
                n_phase = endec_pkg::PH_PLAIN;
            end
            default: begin
                if (plain_to_esc) n_phase = endec_pkg::PH_ESC;
            end
        endcase
        if (i_last) begin
            n_phase = endec_pkg::PH_PLAIN;
            n_hex   = 8'd0;
        end
    end

    // Emitted bytes
    always_comb begin
        cnt = 2'd0;
        b0  = i_byte;
        b1  = i_byte;
        case (r_phase)
            endec_pkg::PH_ESC: begin
                if (is_x) begin
                    b0 = 8'd0;
                    if (i_last) cnt = 2'd1;
                end else if (is_u_code) begin
                    b0 = i_escape_char;
                    b1 = endec_pkg::CH_U_LO;
                    if (i_last) cnt = 2'd2;
                end else begin
                    cnt = 2'd1;
                    if (mode == endec_pkg::MODE_LETTERS && !is_esc && lc[8]) begin
                        b0 = lc[7:0];
                    end
                end
            end
            endec_pkg::PH_HEX0, endec_pkg::PH_HEX1: begin
                if (hd[4]) begin
                    b0 = acc;
                    if (r_phase == endec_pkg::PH_HEX1 || i_last) cnt = 2'd1;
                end else begin
                    // run cut short: gathered value, then the byte as plain unless it opens a new escape
                    b0  = r_hex;
                    b1  = plain_out;
                    cnt = plain_emit ? 2'd2 : 2'd1;
                end
            end
            endec_pkg::PH_UPPER: begin
                cnt = 2'd1;
                b0  = endec_pkg::upper_case(i_byte);
            end
            default: begin
                b0  = plain_out;
                cnt = plain_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    assign o_push        = accept && (cnt != 2'd0);
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.byte0 = b0;
    assign o_entry.byte1 = b1;
    assign o_entry.fin   = i_last;

    // Phase and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= endec_pkg::PH_PLAIN;
            r_hex   <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
        end
    end

endmodule

>>> rtl/endec_queue.sv
// Short queue of decoded entries between the front and back ends.
module endec_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  endec_pkg::t_entry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output endec_pkg::t_entry o_head
);

    endec_pkg::t_entry r_mem [endec_pkg::Q_DEPTH];
    logic [endec_pkg::Q_AW-1:0] r_wptr, r_rptr;
    logic [endec_pkg::Q_AW:0]   r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == (endec_pkg::Q_AW+1)'(endec_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/endec_back.sv
// Back end: splits each queue entry into output transactions behind an output register.
module endec_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  endec_pkg::t_entry i_head,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [7:0]        o_tdata,
    output logic              o_tlast,
    output logic              o_tuser
);

    logic       r_sub;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_oend;

    logic       load;
    logic       run_end;

    assign load    = (!r_ovalid || i_tready) && i_valid;
    assign run_end = !i_head.two || r_sub;
    assign o_pop   = load && run_end;

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_obyte;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_oend;

    // Control: output valid and which byte of the head entry is next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_sub    <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_sub    <= !run_end;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= r_sub ? i_head.byte1 : i_head.byte0;
            r_olast <= run_end;
            r_oend  <= run_end && i_head.fin;
        end
    end

endmodule

>>> rtl/escaped_name_decoder.sv
// Top level of the escaped name decoder: config registers, front, queue, back.
//
// Takes one escaped byte per cycle on the input stream and never stalls while
// the queue has room; each input yields zero, one or two decoded bytes, and the
// output register sends one byte per cycle while m_axis_tready is high, so an
// input that yields two bytes sends them as two separate output transfers. A byte
// passes through the queue and then the output register before it is presented
// on the output. The four-entry queue between the front end and the output stage
// absorbs the second bytes and output stalls; input ready falls only when it is
// full. Registers: escape character at byte address 0 (reset 0x5C), decode mode
// at address 4 (reset 2); write them only while no decoding is in progress.
module escaped_name_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
    input  logic                         s_axis_tlast,   // in_last
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] out_byte
    output logic                         m_axis_tlast,   // run_last
    output logic                         m_axis_tuser,   // string_end
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [endec_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0] r_escape_char;
    logic [1:0] r_decode_mode;

    logic              wr_en;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    endec_pkg::t_entry fe_entry;
    endec_pkg::t_entry q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_char <= endec_pkg::RST_ESCAPE_CHAR;
            r_decode_mode <= endec_pkg::RST_DECODE_MODE;
        end else if (wr_en) begin
            case (paddr)
                endec_pkg::ADDR_ESCAPE_CHAR: r_escape_char <= pwdata[7:0];
                endec_pkg::ADDR_DECODE_MODE: r_decode_mode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr)
            endec_pkg::ADDR_ESCAPE_CHAR: prdata = {24'd0, r_escape_char};
            endec_pkg::ADDR_DECODE_MODE: prdata = {30'd0, r_decode_mode};
            default:                     prdata = 32'd0;
        endcase
    end

    endec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_escape_char (r_escape_char),
        .i_decode_mode (r_decode_mode),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (fe_entry)
    );

    endec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (fe_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    endec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule
